// ===== rtl/brb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer with burst admission.
// ----------------------------------------------------------------------------
package brb_pkg;

  // Storage depth and index width
  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);

  // Item kinds
  localparam logic [1:0] CMD_FLUSH = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_WRITE_OK  = 3'd0;
  localparam logic [2:0] ST_READ_OK   = 3'd1;
  localparam logic [2:0] ST_FULL_REJ  = 3'd2;
  localparam logic [2:0] ST_EMPTY_REJ = 3'd3;
  localparam logic [2:0] ST_FLUSHED   = 3'd4;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // capture the accepted request
    logic exec;        // evaluate request, update ring state, drive RAM
    logic rd_capture;  // latch RAM read data into the result register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic read_go;     // current request is a successful read
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/byte_ring_buffer_burst_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_core
// Byte ring buffer with all-or-nothing write and read bursts.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  --------  ----------------------  --------------------------------------------
//  request   in_valid / in_stall     command, data_in, burst_first, burst_count
//  result    out_valid / out_stall   data_out, status
//  config    cfg_we                  cfg_data (buffer length)
//
//  Each request produces exactly one result. The taken request moves to the
//  execute state, which registers the status; a successful read then waits in
//  a read-wait state on the registered storage read port for its data. No new
//  request is taken in those states. A new request may be accepted while the
//  previous result is still stalled; it is held and executed once that result
//  has been taken.
//  Reset (rst, synchronous) sets the length to 255, clears both indices and
//  the burst state; storage contents are left as they are.
//  Writing cfg_data also clears the indices and any burst in progress.
//
module byte_ring_buffer_burst_core (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  // request channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [7:0] data_in,
  input  wire logic       burst_first,
  input  wire logic [7:0] burst_count,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_out,
  output logic [2:0]      status
);
  import brb_pkg::*;

  dp_cmd_t dcmd;
  dp_sts_t dsts;

  // Sequencer: owns both handshakes, steps the datapath
  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dcmd),
    .sts       (dsts)
  );

  // Datapath: ring indices, burst admission, storage RAM, result register
  brb_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .command     (command),
    .data_in     (data_in),
    .burst_first (burst_first),
    .burst_count (burst_count),
    .cmd         (dcmd),
    .sts         (dsts),
    .data_out    (data_out),
    .status      (status)
  );

endmodule

`default_nettype wire

// ===== rtl/brb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/brb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer: request intake, execute, read wait and result hand-off.
// ----------------------------------------------------------------------------
module brb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output brb_pkg::dp_cmd_t      cmd,
  input  wire brb_pkg::dp_sts_t sts
);
  import brb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_OUT    = 3'd3;
  localparam logic [2:0] S_PEND   = 3'd4;  // result waiting, next request held

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_acc;
  logic       out_acc;

  assign in_stall  = !((state == S_IDLE) || (state == S_OUT));
  assign out_valid = (state == S_OUT) || (state == S_PEND);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.load       = in_acc;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.read_go ? S_RDWAIT : S_OUT;
      end
      S_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (in_acc) begin
          state_next = out_acc ? S_EXEC : S_PEND;
        end else if (out_acc) begin
          state_next = S_IDLE;
        end
      end
      S_PEND: begin
        if (out_acc) state_next = S_EXEC;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brb_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_dpath
// Ring indices, burst admission, length register, storage and result register.
// ----------------------------------------------------------------------------
module brb_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [7:0]                cfg_data,
  input  wire logic [1:0]                command,
  input  wire logic [7:0]                data_in,
  input  wire logic                      burst_first,
  input  wire logic [7:0]                burst_count,
  input  wire brb_pkg::dp_cmd_t          cmd,
  output brb_pkg::dp_sts_t               sts,
  output logic [7:0]                     data_out,
  output logic [2:0]                     status
);
  import brb_pkg::*;

  // Captured request
  logic [1:0]       cmd_q;
  logic [7:0]       data_q;
  logic             first_q;
  logic [7:0]       count_q;

  // Ring state
  logic [7:0]       length;
  logic [IDX_W-1:0] w_idx;
  logic [IDX_W-1:0] r_idx;
  logic             b_acc;
  logic [7:0]       b_rem;

  // Evaluation
  logic [7:0]       len;
  logic [8:0]       fill_w;
  logic [7:0]       fill;
  logic [7:0]       space;
  logic             is_write;
  logic             is_read;
  logic             acc_eff;
  logic [7:0]       rem_eff;
  logic             can_do;
  logic             go;
  logic [8:0]       w_inc;
  logic [8:0]       r_inc;
  logic [IDX_W-1:0] w_wrap;
  logic [IDX_W-1:0] r_wrap;
  logic             ram_we;
  logic [7:0]       ram_rdata;

  // Effective length: at least 2; an 8-bit length never exceeds the depth
  assign len = (length < 8'd2) ? 8'd2 : length;

  assign fill_w = ({1'b0, w_idx} >= {1'b0, r_idx})
                ? ({1'b0, w_idx} - {1'b0, r_idx})
                : ({1'b0, w_idx} + {1'b0, len} - {1'b0, r_idx});
  assign fill   = fill_w[7:0];
  assign space  = len - 8'd1 - fill;

  assign is_write = (cmd_q == CMD_WRITE);
  assign is_read  = (cmd_q == CMD_READ);

  // Burst start re-evaluates admission, abandoning any burst in progress
  always_comb begin
    acc_eff = b_acc;
    rem_eff = b_rem;
    if (first_q) begin
      acc_eff = (count_q != 8'd0) && (count_q <= (is_write ? space : fill));
      rem_eff = acc_eff ? count_q : 8'd0;
    end
  end

  assign can_do = is_write ? (space != 8'd0) : (fill != 8'd0);
  assign go     = acc_eff && (rem_eff != 8'd0) && can_do;

  assign sts.read_go = is_read && go;

  assign w_inc  = {1'b0, w_idx} + 9'd1;
  assign r_inc  = {1'b0, r_idx} + 9'd1;
  assign w_wrap = (w_inc >= {1'b0, len}) ? '0 : w_inc[IDX_W-1:0];
  assign r_wrap = (r_inc >= {1'b0, len}) ? '0 : r_inc[IDX_W-1:0];

  assign ram_we = cmd.exec && is_write && go;

  brb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_idx),
    .wdata (data_q),
    .raddr (r_idx),
    .rdata (ram_rdata)
  );

  // Request capture and result register (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= command;
      data_q  <= data_in;
      first_q <= burst_first;
      count_q <= burst_count;
    end
    if (cmd.exec) begin
      data_out <= 8'd0;
      if (cmd_q == CMD_FLUSH) begin
        status <= ST_FLUSHED;
      end else if (!(is_write || is_read)) begin
        status <= ST_EMPTY_REJ;
      end else if (go) begin
        status <= is_write ? ST_WRITE_OK : ST_READ_OK;
      end else begin
        status <= is_write ? ST_FULL_REJ : ST_EMPTY_REJ;
      end
    end else if (cmd.rd_capture) begin
      data_out <= ram_rdata;
    end
  end

  // Ring control state
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= 8'd255;
      w_idx  <= '0;
      r_idx  <= '0;
      b_acc  <= 1'b0;
      b_rem  <= 8'd0;
    end else if (cfg_we) begin
      length <= cfg_data;
      w_idx  <= '0;
      r_idx  <= '0;
      b_acc  <= 1'b0;
      b_rem  <= 8'd0;
    end else if (cmd.exec) begin
      if (cmd_q == CMD_FLUSH) begin
        w_idx <= '0;
        r_idx <= '0;
        b_acc <= 1'b0;
        b_rem <= 8'd0;
      end else if (is_write || is_read) begin
        if (go) begin
          if (is_write) begin
            w_idx <= w_wrap;
          end else begin
            r_idx <= r_wrap;
          end
          b_rem <= rem_eff - 8'd1;
          b_acc <= (rem_eff != 8'd1);
        end else begin
          b_acc <= 1'b0;
          b_rem <= 8'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire
